// ----- rtl/drr_pkg.sv -----
// Shared types and constants for the decline rate regression block.
// Used by drr_ctrl, drr_datapath and decline_rate_regression.
package drr_pkg;

    localparam int TIME_WIDTH_DEF = 16;
    localparam int LN_IN_W        = 33;
    localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
    localparam logic [6:0] DIV_STEPS  = 7'd32;
    localparam logic [6:0] SQ_STEPS   = 7'd24;
    localparam logic [6:0] FIT_STEPS  = 7'd64;
    localparam logic [6:0] FRAC_STEPS = 7'd24;

    localparam logic CFG_PRODUCT_SELECT = 1'b0;
    localparam logic CFG_TIME_TRANSFORM = 1'b1;

    localparam logic KIND_WELL = 1'b0;
    localparam logic KIND_FIT  = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_LNQ_INIT,
        OP_LNG_INIT,
        OP_NORM_STEP,
        OP_SQ_INIT,
        OP_SQ_STEP,
        OP_LN_MUL,
        OP_LN_RND,
        OP_FIRST,
        OP_MUL_A,
        OP_ACC_A,
        OP_MUL_B,
        OP_ACC_B,
        OP_MUL_T,
        OP_ACC_T,
        OP_EMIT_WELL,
        OP_FIT_INIT,
        OP_FIT_STEP,
        OP_FRAC_INIT,
        OP_FRAC_STEP,
        OP_EMIT_FIT
    } drr_op_t;

    typedef struct packed {
        logic use_rec;
        logic eow;
        logic eos;
        logic started;
        logic tmode;
        logic cnt_zero;
        logic norm_done;
        logic out_free;
        logic den_zero;
    } drr_status_t;

endpackage

// ----- rtl/drr_ctrl.sv -----
// Sequencer for the decline rate regression block.
// Depends on drr_pkg; drives drr_datapath through drr_op_t commands.
module drr_ctrl
    import drr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rec_valid,
    output logic        rec_stall,
    input  drr_status_t status,
    output drr_op_t     op
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_DIV, S_NORM, S_SQ, S_LNMUL, S_LNRND,
        S_MUL_A, S_ACC_A, S_MUL_B, S_ACC_B, S_MUL_T, S_ACC_T,
        S_EOW, S_FIT_INIT, S_FIT_DIV, S_FRAC, S_FIT_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   lng_reg, lng_next;

    assign rec_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        lng_next   = lng_reg;
        op         = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (rec_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.use_rec)
                begin
                    op         = OP_DIV_INIT;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_EOW;
                end
            end
            S_DIV:
            begin
                if (status.cnt_zero)
                begin
                    op         = OP_LNQ_INIT;
                    lng_next   = 1'b0;
                    state_next = S_NORM;
                end
                else
                begin
                    op = OP_DIV_STEP;
                end
            end
            S_NORM:
            begin
                if (status.norm_done)
                begin
                    op         = OP_SQ_INIT;
                    state_next = S_SQ;
                end
                else
                begin
                    op = OP_NORM_STEP;
                end
            end
            S_SQ:
            begin
                if (status.cnt_zero)
                begin
                    state_next = S_LNMUL;
                end
                else
                begin
                    op = OP_SQ_STEP;
                end
            end
            S_LNMUL:
            begin
                op         = OP_LN_MUL;
                state_next = S_LNRND;
            end
            S_LNRND:
            begin
                op = OP_LN_RND;
                if (lng_reg)
                begin
                    state_next = S_MUL_A;
                end
                else if (!status.started)
                begin
                    state_next = S_CHECK;
                end
                else if (status.tmode)
                begin
                    state_next = S_NORM;
                end
                else
                begin
                    state_next = S_MUL_A;
                end
                // first-record and ln(1+t) hand-offs
                if (!lng_reg && !status.started)
                begin
                    state_next = S_EOW;
                end
            end
            S_MUL_A:
            begin
                op         = OP_MUL_A;
                state_next = S_ACC_A;
            end
            S_ACC_A:
            begin
                op         = OP_ACC_A;
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                op         = OP_MUL_B;
                state_next = S_ACC_B;
            end
            S_ACC_B:
            begin
                op         = OP_ACC_B;
                state_next = S_MUL_T;
            end
            S_MUL_T:
            begin
                op         = OP_MUL_T;
                state_next = S_ACC_T;
            end
            S_ACC_T:
            begin
                op         = OP_ACC_T;
                state_next = S_EOW;
            end
            S_EOW:
            begin
                if (!status.eow && !status.eos)
                begin
                    state_next = S_IDLE;
                end
                else if (status.out_free)
                begin
                    op         = OP_EMIT_WELL;
                    state_next = status.eos ? S_FIT_INIT : S_IDLE;
                end
            end
            S_FIT_INIT:
            begin
                if (status.den_zero)
                begin
                    state_next = S_FIT_OUT;
                end
                else
                begin
                    op         = OP_FIT_INIT;
                    state_next = S_FIT_DIV;
                end
            end
            S_FIT_DIV:
            begin
                if (!status.cnt_zero)
                begin
                    op = OP_FIT_STEP;
                end
                else if (status.tmode)
                begin
                    op         = OP_FRAC_INIT;
                    state_next = S_FRAC;
                end
                else
                begin
                    state_next = S_FIT_OUT;
                end
            end
            S_FRAC:
            begin
                if (status.cnt_zero)
                begin
                    state_next = S_FIT_OUT;
                end
                else
                begin
                    op = OP_FRAC_STEP;
                end
            end
            S_FIT_OUT:
            begin
                if (status.out_free)
                begin
                    op         = OP_EMIT_FIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // second ln pass (g = ln(1+t)) starts from the rate ln result
        if (state_reg == S_LNRND && !lng_reg && status.started && status.tmode)
        begin
            op         = OP_LN_RND;
            lng_next   = 1'b1;
            state_next = S_NORM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lng_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lng_reg   <= lng_next;
        end
    end

endmodule

// ----- rtl/drr_datapath.sv -----
// Datapath: rate divider, fixed-point ln, accumulators, fit divider, result register.
// Depends on drr_pkg; sequenced by drr_ctrl.
module drr_datapath
    import drr_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  drr_op_t               op,
    output drr_status_t           status,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic                  cfg_data,
    input  logic                  record_valid,
    input  logic [31:0]           oil_volume,
    input  logic [31:0]           water_volume,
    input  logic [15:0]           interval_length,
    input  logic [TIME_WIDTH-1:0] record_time,
    input  logic                  end_of_well,
    input  logic                  end_of_set,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic                  result_kind,
    output logic [15:0]           well_number,
    output logic [15:0]           start_time,
    output logic [31:0]           initial_rate,
    output logic signed [31:0]    decline_value,
    output logic                  fit_error,
    output logic                  last
);

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;

    // control state
    logic        psel_reg, tmode_reg;
    logic        use_reg, eow_reg, eos_reg;
    logic [6:0]  cnt_reg;
    logic        started_reg;
    logic signed [63:0] a_reg, b_reg;
    logic [63:0] tsum_reg;
    logic [15:0] wcnt_reg;
    logic        res_valid_reg;

    // payload
    logic [31:0] vol_reg;
    logic [15:0] dt_reg;
    logic [TIME_WIDTH-1:0] t_reg;
    logic [15:0] rem_reg;
    logic [31:0] quo_reg;
    logic [LN_IN_W-1:0] s_reg;
    logic [5:0]  p_reg;
    logic        fb_reg, tgt_reg, lsign_reg;
    logic [31:0] m_reg;
    logic [23:0] f_reg;
    logic [63:0] mul_reg;
    logic [31:0] lnq_reg, g_reg;
    logic [31:0] frate_reg, flog_reg;
    logic [TIME_WIDTH-1:0] ftime_reg;
    logic [63:0] frem_reg, fquo_reg;
    logic        fneg_reg;
    logic        kind_reg, err_reg, last_reg;
    logic [15:0] wnum_reg, stime_reg;
    logic [31:0] irate_reg, dval_reg;

    logic [31:0] mul_a, mul_b, g_val, lnq_mag, flog_mag, l2, l2_mag, rnd, ln_val;
    logic [63:0] prod, rnd_sum, tshift, term, num, cap, qcap;
    logic [7:0]  pfb;
    logic [32:0] sq_sh;
    logic [16:0] dtmp;
    logic        dge;
    logic [64:0] ftmp, frtmp, tsum_ext;
    logic        fge, frge;
    logic signed [63:0] acc_in, acc_sum;
    logic        acc_sign, acc_ovf;
    logic [31:0] vol_sel, d_val;

    assign vol_sel  = psel_reg ? water_volume : oil_volume;
    assign g_val    = tmode_reg ? g_reg : 32'(t_reg);
    assign lnq_mag  = lnq_reg[31] ? (32'd0 - lnq_reg) : lnq_reg;
    assign flog_mag = flog_reg[31] ? (32'd0 - flog_reg) : flog_reg;
    assign pfb      = {2'b00, p_reg} - (fb_reg ? 8'd16 : 8'd0);
    assign l2       = {pfb, f_reg};
    assign l2_mag   = l2[31] ? (32'd0 - l2) : l2;

    always_comb
    begin
        case (op)
            OP_SQ_STEP:
            begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            OP_LN_MUL:
            begin
                mul_a = l2_mag;
                mul_b = LN2_Q32;
            end
            OP_MUL_A:
            begin
                mul_a = lnq_mag;
                mul_b = g_val;
            end
            OP_MUL_B:
            begin
                mul_a = flog_mag;
                mul_b = g_val;
            end
            OP_MUL_T:
            begin
                mul_a = g_val;
                mul_b = g_val;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign prod    = 64'(mul_a) * 64'(mul_b);
    assign sq_sh   = prod[63:31];
    assign rnd_sum = mul_reg + 64'h0000_0000_8000_0000;
    assign rnd     = rnd_sum[63:32];
    assign ln_val  = lsign_reg ? (32'd0 - rnd) : rnd;

    assign tshift   = tmode_reg ? (mul_reg >> 24) : mul_reg;
    assign acc_sign = (op == OP_ACC_B) ? flog_reg[31] : lnq_reg[31];
    assign term     = acc_sign ? (64'd0 - tshift) : tshift;
    assign acc_in   = (op == OP_ACC_B) ? b_reg : a_reg;
    assign acc_sum  = acc_in + $signed(term);
    assign acc_ovf  = (acc_in[63] == term[63]) && (acc_sum[63] != acc_in[63]);
    assign tsum_ext = {1'b0, tsum_reg} + {1'b0, tshift};

    assign dtmp = {rem_reg, quo_reg[31]};
    assign dge  = dtmp >= {1'b0, dt_reg};

    assign num   = (b_reg >= a_reg) ? (b_reg - a_reg) : (a_reg - b_reg);
    assign ftmp  = {frem_reg, fquo_reg[63]};
    assign fge   = ftmp >= {1'b0, tsum_reg};
    assign frtmp = {frem_reg, 1'b0};
    assign frge  = frtmp >= {1'b0, tsum_reg};
    assign cap   = fneg_reg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
    assign qcap  = (fquo_reg > cap) ? cap : fquo_reg;
    assign d_val = fneg_reg ? (32'd0 - qcap[31:0]) : qcap[31:0];

    assign status.use_rec   = use_reg;
    assign status.eow       = eow_reg;
    assign status.eos       = eos_reg;
    assign status.started   = started_reg;
    assign status.tmode     = tmode_reg;
    assign status.cnt_zero  = (cnt_reg == 7'd0);
    assign status.norm_done = s_reg[LN_IN_W-1];
    assign status.out_free  = !res_valid_reg || !res_stall;
    assign status.den_zero  = (tsum_reg == 64'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psel_reg      <= 1'b0;
            tmode_reg     <= 1'b0;
            use_reg       <= 1'b0;
            eow_reg       <= 1'b0;
            eos_reg       <= 1'b0;
            cnt_reg       <= 7'd0;
            started_reg   <= 1'b0;
            a_reg         <= 64'sd0;
            b_reg         <= 64'sd0;
            tsum_reg      <= 64'd0;
            wcnt_reg      <= 16'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PRODUCT_SELECT: psel_reg  <= cfg_data;
                    CFG_TIME_TRANSFORM: tmode_reg <= cfg_data;
                    default:            psel_reg  <= psel_reg;
                endcase
            end
            if (op == OP_EMIT_WELL || op == OP_EMIT_FIT)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            case (op)
                OP_LOAD:
                begin
                    use_reg <= record_valid && (vol_sel != 32'd0);
                    eow_reg <= end_of_well;
                    eos_reg <= end_of_set;
                end
                OP_DIV_INIT:
                begin
                    cnt_reg <= (vol_reg[31:16] >= dt_reg) ? 7'd0 : DIV_STEPS;
                end
                OP_SQ_INIT:  cnt_reg <= SQ_STEPS;
                OP_DIV_STEP, OP_SQ_STEP, OP_FIT_STEP, OP_FRAC_STEP:
                begin
                    cnt_reg <= cnt_reg - 7'd1;
                end
                OP_FIRST:    started_reg <= 1'b1;
                OP_LN_RND:
                begin
                    if (!tgt_reg && !started_reg)
                    begin
                        started_reg <= 1'b1;
                    end
                end
                OP_ACC_A:
                begin
                    a_reg <= acc_ovf ? (term[63] ? S64_MIN : S64_MAX) : acc_sum;
                end
                OP_ACC_B:
                begin
                    b_reg <= acc_ovf ? (term[63] ? S64_MIN : S64_MAX) : acc_sum;
                end
                OP_ACC_T:
                begin
                    tsum_reg <= tsum_ext[64] ? 64'hFFFF_FFFF_FFFF_FFFF : tsum_ext[63:0];
                end
                OP_EMIT_WELL:
                begin
                    wcnt_reg    <= wcnt_reg + 16'd1;
                    started_reg <= 1'b0;
                end
                OP_FIT_INIT: cnt_reg <= FIT_STEPS;
                OP_FRAC_INIT:
                begin
                    cnt_reg <= (fquo_reg >= 64'd128) ? 7'd0 : FRAC_STEPS;
                end
                OP_EMIT_FIT:
                begin
                    a_reg    <= 64'sd0;
                    b_reg    <= 64'sd0;
                    tsum_reg <= 64'd0;
                    wcnt_reg <= 16'd0;
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                vol_reg <= vol_sel;
                dt_reg  <= interval_length;
                t_reg   <= record_time;
            end
            OP_DIV_INIT:
            begin
                rem_reg <= vol_reg[31:16];
                quo_reg <= (vol_reg[31:16] >= dt_reg) ? 32'hFFFF_FFFF
                                                      : {vol_reg[15:0], 16'h0000};
            end
            OP_DIV_STEP:
            begin
                rem_reg <= dge ? 16'(dtmp - {1'b0, dt_reg}) : dtmp[15:0];
                quo_reg <= {quo_reg[30:0], dge};
            end
            OP_LNQ_INIT:
            begin
                s_reg   <= {1'b0, quo_reg};
                p_reg   <= 6'd32;
                fb_reg  <= 1'b1;
                tgt_reg <= 1'b0;
            end
            OP_LN_RND:
            begin
                if (tgt_reg)
                begin
                    g_reg <= ln_val;
                end
                else
                begin
                    lnq_reg <= ln_val;
                    if (!started_reg)
                    begin
                        frate_reg <= quo_reg;
                        flog_reg  <= ln_val;
                        ftime_reg <= t_reg;
                    end
                    else
                    begin
                        // set up ln(1+t); unused when g is the time itself
                        s_reg   <= LN_IN_W'(t_reg) + LN_IN_W'(1);
                        p_reg   <= 6'd32;
                        fb_reg  <= 1'b0;
                        tgt_reg <= 1'b1;
                    end
                end
            end
            OP_NORM_STEP:
            begin
                s_reg <= {s_reg[LN_IN_W-2:0], 1'b0};
                p_reg <= p_reg - 6'd1;
            end
            OP_SQ_INIT:
            begin
                m_reg <= s_reg[LN_IN_W-1:1];
                f_reg <= 24'd0;
            end
            OP_SQ_STEP:
            begin
                m_reg <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
                f_reg <= {f_reg[22:0], sq_sh[32]};
            end
            OP_LN_MUL:
            begin
                mul_reg   <= prod;
                lsign_reg <= l2[31];
            end
            OP_MUL_A, OP_MUL_B, OP_MUL_T:
            begin
                mul_reg <= prod;
            end
            OP_EMIT_WELL:
            begin
                kind_reg  <= KIND_WELL;
                wnum_reg  <= wcnt_reg;
                stime_reg <= started_reg ? 16'(ftime_reg) : 16'd0;
                irate_reg <= started_reg ? frate_reg : 32'd0;
                dval_reg  <= 32'd0;
                err_reg   <= 1'b0;
                last_reg  <= !eos_reg;
            end
            OP_FIT_INIT:
            begin
                frem_reg <= 64'd0;
                fquo_reg <= num;
                fneg_reg <= (b_reg < a_reg);
            end
            OP_FIT_STEP:
            begin
                frem_reg <= fge ? 64'(ftmp - {1'b0, tsum_reg}) : ftmp[63:0];
                fquo_reg <= {fquo_reg[62:0], fge};
            end
            OP_FRAC_INIT:
            begin
                if (fquo_reg >= 64'd128)
                begin
                    fquo_reg <= 64'hFFFF_FFFF_FFFF_FFFF;
                end
            end
            OP_FRAC_STEP:
            begin
                frem_reg <= frge ? 64'(frtmp - {1'b0, tsum_reg}) : frtmp[63:0];
                fquo_reg <= {fquo_reg[62:0], frge};
            end
            OP_EMIT_FIT:
            begin
                kind_reg  <= KIND_FIT;
                wnum_reg  <= 16'd0;
                stime_reg <= 16'd0;
                irate_reg <= 32'd0;
                dval_reg  <= status.den_zero ? 32'd0 : d_val;
                err_reg   <= status.den_zero;
                last_reg  <= 1'b1;
            end
            default:
            begin
                mul_reg <= mul_reg;
            end
        endcase
    end

    assign res_valid     = res_valid_reg;
    assign result_kind   = kind_reg;
    assign well_number   = wnum_reg;
    assign start_time    = stime_reg;
    assign initial_rate  = irate_reg;
    assign decline_value = dval_reg;
    assign fit_error     = err_reg;
    assign last          = last_reg;

endmodule

// ----- rtl/decline_rate_regression.sv -----
// Top level: exponential decline curve least-squares fit over production records.
// Depends on drr_pkg, drr_ctrl and drr_datapath.
//
//  channel   handshake             payload
//  record    rec_valid/rec_stall   record_valid .. end_of_set
//  result    res_valid/res_stall   result_kind .. last
//  config    cfg_write             cfg_index, cfg_data
//
// A skipped record goes from the check state straight to end-of-well handling; a used record
// runs the 32-step rate divider (skipped when the rate saturates), the one-bit-per-cycle
// normalize and the 24 squaring steps of the ln unit (run again for ln(1+t) in mode 1).
// End of set runs the 64 fit division steps, and in mode 1 also the fraction steps.
// Reset clears configuration, accumulators and well count; no clearing pass.
// A stalled result holds; the next record is taken while a result waits, and a new
// result waits until the output register frees.
module decline_rate_regression
    import drr_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic                  cfg_data,
    input  logic                  rec_valid,
    output logic                  rec_stall,
    input  logic                  record_valid,
    input  logic [31:0]           oil_volume,
    input  logic [31:0]           water_volume,
    input  logic [15:0]           interval_length,
    input  logic [TIME_WIDTH-1:0] record_time,
    input  logic                  end_of_well,
    input  logic                  end_of_set,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic                  result_kind,
    output logic [15:0]           well_number,
    output logic [15:0]           start_time,
    output logic [31:0]           initial_rate,
    output logic signed [31:0]    decline_value,
    output logic                  fit_error,
    output logic                  last
);

    drr_op_t     op;
    drr_status_t status;

    drr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .status    (status),
        .op        (op)
    );

    drr_datapath #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .op              (op),
        .status          (status),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .record_valid    (record_valid),
        .oil_volume      (oil_volume),
        .water_volume    (water_volume),
        .interval_length (interval_length),
        .record_time     (record_time),
        .end_of_well     (end_of_well),
        .end_of_set      (end_of_set),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .result_kind     (result_kind),
        .well_number     (well_number),
        .start_time      (start_time),
        .initial_rate    (initial_rate),
        .decline_value   (decline_value),
        .fit_error       (fit_error),
        .last            (last)
    );

endmodule
